### hdl/cste_pkg.sv
// shared types, codes and reset values of the spiking tick engine
`timescale 1ns / 1ps

package cste_pkg;

  localparam int DEF_MAX_CELLS       = 512;
  localparam int DEF_MAX_CONNECTIONS = 8192;

  localparam logic [2:0] ACT_LIST  = 3'd0;
  localparam logic [2:0] ACT_CONN  = 3'd1;
  localparam logic [2:0] ACT_STIM  = 3'd2;
  localparam logic [2:0] ACT_TICK  = 3'd3;
  localparam logic [2:0] ACT_QUERY = 3'd4;

  localparam logic [1:0] REG_NEURON_COUNT   = 2'd0;
  localparam logic [1:0] REG_CELL_COUNT     = 2'd1;
  localparam logic [1:0] REG_FIRE_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_IDLE_LIMIT     = 2'd3;

  localparam logic [9:0]        RST_NEURON_COUNT   = 10'd302;
  localparam logic [9:0]        RST_CELL_COUNT     = 10'd397;
  localparam logic signed [7:0] RST_FIRE_THRESHOLD = 8'sd30;
  localparam logic [6:0]        RST_IDLE_LIMIT     = 7'd10;

  localparam logic [6:0]         IDLE_MAX = 7'd127;
  localparam logic signed [16:0] SAT_HI   = 17'sd127;
  localparam logic signed [16:0] SAT_LO   = -17'sd128;

  typedef struct packed {
    logic [15:0] now;
    logic [15:0] nxt;
    logic        fired;
    logic [6:0]  idle;
  } cell_word_t;

  typedef struct packed {
    logic [8:0] target;
    logic [7:0] weight;
  } conn_entry_t;

endpackage

### hdl/cste_ram.sv
// single-port synchronous memory with registered read
`timescale 1ns / 1ps

module cste_ram #(
  parameter int DEPTH = cste_pkg::DEF_MAX_CELLS,
  parameter int WIDTH = $bits(cste_pkg::cell_word_t)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/connectome_spiking_tick_engine.sv
// top level: sequencer of the spiking tick engine over its cell, list and connection memories
//
//  channel  | direction | handshake             | payload
//  request  | in        | in_valid / in_ready   | action, cell_id, conn_slot, target_id, weight
//  result   | out       | out_valid / out_ready | state_value, discharged, idle_level, status
//  config   | in        | cfg_we                | cfg_index, cfg_data
//
// a list or connection request writes its memory, a query reads the cell memory; a stimulate walks
// the connection list of its neuron, and a tick checks every neuron, walks the list of each firing
// neuron and then updates every cell, all paced by the single port of the cell memory
// after reset a clearing pass zeroes every word of the cell memory, in_ready low
// one request at a time; a result waiting for out_ready holds off the next one
`timescale 1ns / 1ps

module connectome_spiking_tick_engine #(
  parameter int MAX_CELLS       = cste_pkg::DEF_MAX_CELLS,
  parameter int MAX_CONNECTIONS = cste_pkg::DEF_MAX_CONNECTIONS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic [9:0]         cell_id,
  input  logic [13:0]        conn_slot,
  input  logic [8:0]         target_id,
  input  logic signed [7:0]  weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] state_value,
  output logic               discharged,
  output logic [6:0]         idle_level,
  output logic               status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data
);

  localparam int CAW   = $clog2(MAX_CELLS);
  localparam int LAW   = $clog2(MAX_CELLS + 1);
  localparam int KAW   = $clog2(MAX_CONNECTIONS);
  localparam int CNT_W = $clog2(MAX_CELLS + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RESP  = 4'd2;
  localparam logic [3:0] S_QRY   = 4'd3;
  localparam logic [3:0] S_PLS0  = 4'd4;
  localparam logic [3:0] S_PLS1  = 4'd5;
  localparam logic [3:0] S_PLS2  = 4'd6;
  localparam logic [3:0] S_PCONN = 4'd7;
  localparam logic [3:0] S_PRMW  = 4'd8;
  localparam logic [3:0] S_TRD   = 4'd9;
  localparam logic [3:0] S_TCHK  = 4'd10;
  localparam logic [3:0] S_TRD2  = 4'd11;
  localparam logic [3:0] S_TSET  = 4'd12;
  localparam logic [3:0] S_URD   = 4'd13;
  localparam logic [3:0] S_UWR   = 4'd14;

  // configuration
  logic [9:0]        neuron_count;
  logic [9:0]        cell_count;
  logic signed [7:0] fire_threshold;
  logic [6:0]        idle_limit;
  logic [CNT_W-1:0]  c_eff;
  logic [CNT_W-1:0]  n_eff;

  // sequencer
  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CAW-1:0]   ping_id, ping_id_next;
  logic [13:0]      a_cur, a_cur_next;
  logic [13:0]      a_end, a_end_next;
  logic             in_tick, in_tick_next;
  logic             qry_neuron, qry_neuron_next;
  logic [8:0]       tgt, tgt_next;
  logic signed [7:0] wgt, wgt_next;

  logic [15:0] res_value, res_value_next;
  logic        res_dis, res_dis_next;
  logic [6:0]  res_idle, res_idle_next;
  logic        res_status, res_status_next;

  // memory ports
  logic                   cell_we;
  logic [CAW-1:0]         cell_addr;
  cste_pkg::cell_word_t   cell_wdata, cell_rdata;
  logic                   ls_we;
  logic [LAW-1:0]         ls_addr;
  logic [13:0]            ls_wdata, ls_rdata;
  logic                   conn_we;
  logic [KAW-1:0]         conn_addr;
  cste_pkg::conn_entry_t  conn_wdata, conn_rdata;

  // datapath helpers
  logic [13:0]          end_clamped;
  logic [13:0]          a_inc;
  logic [3:0]           ret_state;
  logic signed [15:0]   now_s;
  logic signed [15:0]   thr_s;
  logic signed [16:0]   sat_sum;
  logic signed [16:0]   sat_val;
  logic [15:0]          wrap_val;
  logic                 tgt_neuron;
  logic [6:0]           idle_inc;
  cste_pkg::cell_word_t upd_word;
  logic                 accept;

  assign c_eff = CNT_W'((32'(cell_count) < MAX_CELLS) ? 32'(cell_count) : MAX_CELLS);
  assign n_eff = (32'(neuron_count) < 32'(c_eff)) ? CNT_W'(neuron_count) : c_eff;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign end_clamped = (32'(ls_rdata) > MAX_CONNECTIONS) ? 14'(MAX_CONNECTIONS) : ls_rdata;
  assign a_inc       = a_cur + 14'd1;
  assign ret_state   = in_tick ? S_TRD2 : S_RESP;
  assign now_s       = $signed(cell_rdata.now);
  assign thr_s       = 16'(fire_threshold);
  assign tgt_neuron  = 32'(tgt) < 32'(n_eff);
  assign sat_sum     = 17'($signed(cell_rdata.nxt)) + 17'(wgt);
  assign sat_val     = (sat_sum > cste_pkg::SAT_HI) ? cste_pkg::SAT_HI :
                       (sat_sum < cste_pkg::SAT_LO) ? cste_pkg::SAT_LO : sat_sum;
  assign wrap_val    = cell_rdata.nxt + 16'(wgt);
  assign idle_inc    = ((cell_rdata.nxt == cell_rdata.now) &&
                        (cell_rdata.idle != cste_pkg::IDLE_MAX))
                       ? cell_rdata.idle + 7'd1 : cell_rdata.idle;

  always_comb begin
    upd_word = cell_rdata;
    if (32'(idx) < 32'(n_eff)) begin
      upd_word.idle = idle_inc;
      if (cell_rdata.idle > idle_limit) begin
        upd_word.nxt  = '0;
        upd_word.idle = '0;
      end
      upd_word.now = upd_word.nxt;
    end else begin
      upd_word.now = cell_rdata.nxt;
      upd_word.nxt = '0;
    end
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    ping_id_next    = ping_id;
    a_cur_next      = a_cur;
    a_end_next      = a_end;
    in_tick_next    = in_tick;
    qry_neuron_next = qry_neuron;
    tgt_next        = tgt;
    wgt_next        = wgt;
    res_value_next  = res_value;
    res_dis_next    = res_dis;
    res_idle_next   = res_idle;
    res_status_next = res_status;
    cell_we    = 1'b0;
    cell_addr  = idx[CAW-1:0];
    cell_wdata = cell_rdata;
    ls_we      = 1'b0;
    ls_addr    = LAW'(ping_id);
    ls_wdata   = conn_slot;
    conn_we    = 1'b0;
    conn_addr  = KAW'(a_cur);
    conn_wdata = {target_id, weight};
    case (state)
      S_CLR: begin
        cell_we    = 1'b1;
        cell_wdata = '0;
        if (32'(idx) == MAX_CELLS - 1) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_value_next  = '0;
          res_dis_next    = 1'b0;
          res_idle_next   = '0;
          res_status_next = 1'b0;
          state_next      = S_RESP;
          case (action)
            cste_pkg::ACT_LIST: begin
              if (32'(cell_id) <= MAX_CELLS) begin
                ls_we   = 1'b1;
                ls_addr = LAW'(cell_id);
              end else begin
                res_status_next = 1'b1;
              end
            end
            cste_pkg::ACT_CONN: begin
              if (32'(conn_slot) < MAX_CONNECTIONS) begin
                conn_we   = 1'b1;
                conn_addr = KAW'(conn_slot);
              end else begin
                res_status_next = 1'b1;
              end
            end
            cste_pkg::ACT_STIM: begin
              if (32'(cell_id) < 32'(n_eff)) begin
                ping_id_next = CAW'(cell_id);
                in_tick_next = 1'b0;
                state_next   = S_PLS0;
              end else begin
                res_status_next = 1'b1;
              end
            end
            cste_pkg::ACT_TICK: begin
              idx_next     = '0;
              in_tick_next = 1'b1;
              state_next   = S_TRD;
            end
            cste_pkg::ACT_QUERY: begin
              if (32'(cell_id) < 32'(c_eff)) begin
                cell_addr       = CAW'(cell_id);
                qry_neuron_next = 32'(cell_id) < 32'(n_eff);
                state_next      = S_QRY;
              end else begin
                res_status_next = 1'b1;
              end
            end
            default: begin
              res_status_next = 1'b1;
            end
          endcase
        end
      end
      S_QRY: begin
        res_value_next = cell_rdata.now;
        if (qry_neuron) begin
          res_dis_next  = cell_rdata.fired;
          res_idle_next = cell_rdata.idle;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      S_PLS0: begin
        ls_addr    = LAW'(ping_id);
        state_next = S_PLS1;
      end
      S_PLS1: begin
        a_cur_next = ls_rdata;
        ls_addr    = LAW'(ping_id) + LAW'(1);
        state_next = S_PLS2;
      end
      S_PLS2: begin
        a_end_next = end_clamped;
        conn_addr  = KAW'(a_cur);
        state_next = (a_cur < end_clamped) ? S_PCONN : ret_state;
      end
      S_PCONN: begin
        tgt_next = conn_rdata.target;
        wgt_next = $signed(conn_rdata.weight);
        if (32'(conn_rdata.target) < 32'(c_eff)) begin
          cell_addr  = CAW'(conn_rdata.target);
          state_next = S_PRMW;
        end else begin
          a_cur_next = a_inc;
          conn_addr  = KAW'(a_inc);
          state_next = (a_inc < a_end) ? S_PCONN : ret_state;
        end
      end
      S_PRMW: begin
        cell_we    = 1'b1;
        cell_addr  = CAW'(tgt);
        cell_wdata.nxt = tgt_neuron ? 16'(sat_val) : wrap_val;
        a_cur_next = a_inc;
        conn_addr  = KAW'(a_inc);
        state_next = (a_inc < a_end) ? S_PCONN : ret_state;
      end
      S_TRD: begin
        if (32'(idx) < 32'(n_eff)) begin
          state_next = S_TCHK;
        end else begin
          idx_next   = '0;
          state_next = S_URD;
        end
      end
      S_TCHK: begin
        if (now_s > thr_s) begin
          ping_id_next = idx[CAW-1:0];
          state_next   = S_PLS0;
        end else begin
          cell_we          = 1'b1;
          cell_wdata.fired = 1'b0;
          idx_next         = idx + CNT_W'(1);
          state_next       = S_TRD;
        end
      end
      S_TRD2: begin
        cell_addr  = ping_id;
        state_next = S_TSET;
      end
      S_TSET: begin
        cell_we          = 1'b1;
        cell_addr        = ping_id;
        cell_wdata.nxt   = '0;
        cell_wdata.fired = 1'b1;
        idx_next         = idx + CNT_W'(1);
        state_next       = S_TRD;
      end
      S_URD: begin
        state_next = (32'(idx) < 32'(c_eff)) ? S_UWR : S_RESP;
      end
      S_UWR: begin
        cell_we    = 1'b1;
        cell_wdata = upd_word;
        idx_next   = idx + CNT_W'(1);
        state_next = S_URD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      idx            <= '0;
      in_tick        <= 1'b0;
      out_valid      <= 1'b0;
      neuron_count   <= cste_pkg::RST_NEURON_COUNT;
      cell_count     <= cste_pkg::RST_CELL_COUNT;
      fire_threshold <= cste_pkg::RST_FIRE_THRESHOLD;
      idle_limit     <= cste_pkg::RST_IDLE_LIMIT;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      in_tick <= in_tick_next;
      if (state == S_RESP && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          cste_pkg::REG_NEURON_COUNT:   neuron_count   <= cfg_data;
          cste_pkg::REG_CELL_COUNT:     cell_count     <= cfg_data;
          cste_pkg::REG_FIRE_THRESHOLD: fire_threshold <= $signed(cfg_data[7:0]);
          cste_pkg::REG_IDLE_LIMIT:     idle_limit     <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ping_id    <= ping_id_next;
    a_cur      <= a_cur_next;
    a_end      <= a_end_next;
    qry_neuron <= qry_neuron_next;
    tgt        <= tgt_next;
    wgt        <= wgt_next;
    res_value  <= res_value_next;
    res_dis    <= res_dis_next;
    res_idle   <= res_idle_next;
    res_status <= res_status_next;
    if (state == S_RESP && (!out_valid || out_ready)) begin
      state_value <= $signed(res_value);
      discharged  <= res_dis;
      idle_level  <= res_idle;
      status      <= res_status;
    end
  end

  cste_ram #(
    .DEPTH (MAX_CELLS),
    .WIDTH ($bits(cste_pkg::cell_word_t))
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .addr  (cell_addr),
    .wdata (cell_wdata),
    .rdata (cell_rdata)
  );

  cste_ram #(
    .DEPTH (MAX_CELLS + 1),
    .WIDTH (14)
  ) u_list_ram (
    .clk   (clk),
    .we    (ls_we),
    .addr  (ls_addr),
    .wdata (ls_wdata),
    .rdata (ls_rdata)
  );

  cste_ram #(
    .DEPTH (MAX_CONNECTIONS),
    .WIDTH ($bits(cste_pkg::conn_entry_t))
  ) u_conn_ram (
    .clk   (clk),
    .we    (conn_we),
    .addr  (conn_addr),
    .wdata (conn_wdata),
    .rdata (conn_rdata)
  );

  a_conn_write_only_on_request: assert property (@(posedge clk) disable iff (rst)
    (conn_we || ls_we) |-> (state == S_IDLE && in_valid))
    else $error("list or connection write outside an accepted request");

  a_ping_within_list: assert property (@(posedge clk) disable iff (rst)
    (state == S_PCONN || state == S_PRMW) |-> (a_cur < a_end))
    else $error("connection walk beyond list end");

  a_update_within_cells: assert property (@(posedge clk) disable iff (rst)
    (state == S_UWR) |-> (32'(idx) < 32'(c_eff)))
    else $error("tick update beyond cell count");

  a_result_after_resp: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("result not presented after completion");

endmodule

### tb/tb_connectome_spiking_tick_engine.sv
// testbench for the spiking tick engine: directed and random requests checked against a local model
`timescale 1ns / 1ps

module tb_connectome_spiking_tick_engine;

  localparam int NCELL = cste_pkg::DEF_MAX_CELLS;
  localparam int NCONN = cste_pkg::DEF_MAX_CONNECTIONS;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic signed [15:0] sv;
    logic               dis;
    logic [6:0]         idl;
    logic               st;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] action = '0;
  logic [9:0] cell_id = '0;
  logic [13:0] conn_slot = '0;
  logic [8:0] target_id = '0;
  logic signed [7:0] weight = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] state_value;
  logic discharged;
  logic [6:0] idle_level;
  logic status;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  connectome_spiking_tick_engine u_top (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // model state
  int m_neurons, m_cells, m_thr, m_idle_lim;
  logic [15:0] m_now [NCELL];
  logic [15:0] m_next [NCELL];
  logic m_fired [NCELL];
  logic [6:0] m_idle [NCELL];
  logic [13:0] m_start [NCELL+1];
  logic [16:0] m_conn [NCONN];

  answer_t expected_answers[$];
  int errors = 0, requests = 0, answers = 0, ticks = 0, cycles = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit recv_hold = 0;

  function automatic int cells_eff();
    return m_cells < NCELL ? m_cells : NCELL;
  endfunction

  function automatic int neurons_eff();
    return m_neurons < cells_eff() ? m_neurons : cells_eff();
  endfunction

  function automatic void add_weight(int id, int w);
    int v;
    if (id >= cells_eff()) return;
    if (id < neurons_eff()) begin
      v = $signed(m_next[id]) + w;
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      m_next[id] = v[15:0];
    end else begin
      m_next[id] = m_next[id] + w[15:0];
    end
  endfunction

  function automatic void fire_cell(int id);
    int s, e;
    s = int'(m_start[id]);
    e = int'(m_start[id+1]);
    if (e > NCONN) e = NCONN;
    for (int a = s; a < e; a++)
      add_weight(int'(m_conn[a][16:8]), int'($signed(m_conn[a][7:0])));
  endfunction

  function automatic void run_tick();
    int n, c;
    logic [6:0] old;
    n = neurons_eff();
    c = cells_eff();
    for (int i = 0; i < n; i++) begin
      if ($signed(m_now[i]) > m_thr) begin
        fire_cell(i);
        m_next[i] = 0;
        m_fired[i] = 1;
      end else begin
        m_fired[i] = 0;
      end
    end
    for (int i = 0; i < n; i++) begin
      old = m_idle[i];
      if (m_next[i] == m_now[i] && m_idle[i] < cste_pkg::IDLE_MAX) m_idle[i]++;
      if (old > m_idle_lim) begin
        m_next[i] = 0;
        m_idle[i] = 0;
      end
    end
    for (int i = 0; i < c; i++) m_now[i] = m_next[i];
    for (int i = n; i < c; i++) m_next[i] = 0;
  endfunction

  function automatic answer_t predict_answer(logic [2:0] a, int id, int slot, int tgt,
                                             logic [7:0] w);
    answer_t r;
    r = '0;
    case (a)
      cste_pkg::ACT_LIST: if (id <= NCELL) m_start[id] = slot[13:0]; else r.st = 1;
      cste_pkg::ACT_CONN: if (slot < NCONN) m_conn[slot] = {tgt[8:0], w}; else r.st = 1;
      cste_pkg::ACT_STIM: if (id < neurons_eff()) fire_cell(id); else r.st = 1;
      cste_pkg::ACT_TICK: run_tick();
      cste_pkg::ACT_QUERY: if (id < cells_eff()) begin
        r.sv = m_now[id];
        if (id < neurons_eff()) begin
          r.dis = m_fired[id];
          r.idl = m_idle[id];
        end
      end else r.st = 1;
      default: r.st = 1;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, answers);
  endtask

  task automatic send_request(logic [2:0] a, int id, int slot, int tgt, logic [7:0] w);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    expected_answers.push_back(predict_answer(a, id, slot, tgt, w));
    in_valid <= 1;
    action <= a;
    cell_id <= id[9:0];
    conn_slot <= slot[13:0];
    target_id <= tgt[8:0];
    weight <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests++;
    if (a == cste_pkg::ACT_TICK) ticks++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[9:0];
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      cste_pkg::REG_NEURON_COUNT: m_neurons = int'(val[9:0]);
      cste_pkg::REG_CELL_COUNT: m_cells = int'(val[9:0]);
      cste_pkg::REG_FIRE_THRESHOLD: m_thr = int'($signed(val[7:0]));
      default: m_idle_lim = int'(val[6:0]);
    endcase
  endtask

  // a small network: each neuron gets a short list over a compact store
  task automatic build_network(int n);
    int a;
    a = 0;
    for (int i = 0; i <= n; i++) begin
      send_request(cste_pkg::ACT_LIST, i, a, 0, 0);
      if (i < n) begin
        for (int k = 0; k < 2; k++) begin
          send_request(cste_pkg::ACT_CONN, 0, a, $urandom_range(n + 3, 0), 8'($urandom));
          a++;
        end
      end
    end
  endtask

  task automatic random_request(int n);
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 40) send_request(cste_pkg::ACT_STIM, $urandom_range(n + 2, 0), 0, 0, 0);
    else if (pick < 60)
      send_request(cste_pkg::ACT_TICK, $urandom, $urandom, $urandom, 8'($urandom));
    else if (pick < 85) send_request(cste_pkg::ACT_QUERY, $urandom_range(n + 6, 0), 0, 0, 0);
    else if (pick < 93)
      send_request(cste_pkg::ACT_CONN, 0, $urandom_range(2 * n - 1, 0), $urandom,
                   8'($urandom));
    else if (pick < 96)
      send_request(cste_pkg::ACT_CONN, 0, $urandom_range(16383, NCONN), $urandom, 0);
    else send_request(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom, 8'($urandom));
  endtask

  task automatic test_directed();
    write_reg(cste_pkg::REG_NEURON_COUNT, 6);
    write_reg(cste_pkg::REG_CELL_COUNT, 9);
    write_reg(cste_pkg::REG_FIRE_THRESHOLD, -128);
    write_reg(cste_pkg::REG_IDLE_LIMIT, 0);
    build_network(6);
    send_request(cste_pkg::ACT_LIST, NCELL + 1, 0, 0, 0);
    send_request(cste_pkg::ACT_LIST, 1023, 16383, 0, 0);
    send_request(cste_pkg::ACT_CONN, 0, NCONN, 511, 8'h80);
    send_request(cste_pkg::ACT_CONN, 0, 16383, 0, 8'h7f);
    send_request(cste_pkg::ACT_CONN, 0, 3, 511, 8'h7f);
    send_request(cste_pkg::ACT_STIM, 0, 0, 0, 0);
    send_request(cste_pkg::ACT_STIM, 6, 0, 0, 0);
    send_request(cste_pkg::ACT_TICK, 0, 0, 0, 0);
    send_request(cste_pkg::ACT_QUERY, 0, 0, 0, 0);
    send_request(cste_pkg::ACT_QUERY, 7, 0, 0, 0);
    send_request(cste_pkg::ACT_QUERY, 9, 0, 0, 0);
    send_request(cste_pkg::ACT_QUERY, 1023, 0, 0, 0);
    send_request(3'd5, 0, 0, 0, 0);
    send_request(3'd7, 1023, 16383, 511, 8'hff);
    // reversed list, then list running past the store
    send_request(cste_pkg::ACT_LIST, 2, 11, 0, 0);
    send_request(cste_pkg::ACT_STIM, 2, 0, 0, 0);
    send_request(cste_pkg::ACT_LIST, 2, 8200, 0, 0);
    send_request(cste_pkg::ACT_LIST, 3, 16383, 0, 0);
    send_request(cste_pkg::ACT_STIM, 2, 0, 0, 0);
    send_request(cste_pkg::ACT_LIST, 2, 4, 0, 0);
    send_request(cste_pkg::ACT_LIST, 3, 6, 0, 0);
  endtask

  task automatic test_random_phase(int s_pct, int r_pct, int cnt);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < cnt; i++) random_request(8);
  endtask

  task automatic test_counts_and_limits();
    // empty lists for cells that turn into neurons below
    for (int i = 7; i <= 12; i++) send_request(cste_pkg::ACT_LIST, i, 12, 0, 0);
    write_reg(cste_pkg::REG_FIRE_THRESHOLD, 127);
    write_reg(cste_pkg::REG_IDLE_LIMIT, 126);
    write_reg(cste_pkg::REG_NEURON_COUNT, 1023);
    write_reg(cste_pkg::REG_CELL_COUNT, 12);
    send_request(cste_pkg::ACT_TICK, 0, 0, 0, 0);
    send_request(cste_pkg::ACT_QUERY, 11, 0, 0, 0);
    write_reg(cste_pkg::REG_NEURON_COUNT, 0);
    write_reg(cste_pkg::REG_CELL_COUNT, 0);
    send_request(cste_pkg::ACT_TICK, 0, 0, 0, 0);
    send_request(cste_pkg::ACT_QUERY, 0, 0, 0, 0);
    write_reg(cste_pkg::REG_NEURON_COUNT, 8);
    write_reg(cste_pkg::REG_CELL_COUNT, 11);
    write_reg(cste_pkg::REG_FIRE_THRESHOLD, 3);
    write_reg(cste_pkg::REG_IDLE_LIMIT, 2);
  endtask

  task automatic test_backpressure();
    recv_hold = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        recv_hold = 0;
      end
      for (int i = 0; i < 8; i++) random_request(8);
    join
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      out_ready <= !recv_hold && !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        want = expected_answers.pop_front();
        if (state_value !== want.sv) report("state_value", 32'(state_value), 32'(want.sv));
        if (discharged !== want.dis) report("discharged", 32'(discharged), 32'(want.dis));
        if (idle_level !== want.idl) report("idle_level", 32'(idle_level), 32'(want.idl));
        if (status !== want.st) report("status", 32'(status), 32'(want.st));
      end
      answers++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("connectome_spiking_tick_engine test failed");
      $finish;
    end
  end

  initial begin
    m_neurons = int'(cste_pkg::RST_NEURON_COUNT);
    m_cells = int'(cste_pkg::RST_CELL_COUNT);
    m_thr = int'(cste_pkg::RST_FIRE_THRESHOLD);
    m_idle_lim = int'(cste_pkg::RST_IDLE_LIMIT);
    for (int i = 0; i < NCELL; i++) begin
      m_now[i] = 0;
      m_next[i] = 0;
      m_fired[i] = 0;
      m_idle[i] = 0;
    end
    for (int i = 0; i <= NCELL; i++) m_start[i] = 0;
    for (int i = 0; i < NCONN; i++) m_conn[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_counts_and_limits();
    drain();
    build_network(8);
    test_random_phase(11, 66, 10);
    test_random_phase(66, 11, 10);
    test_backpressure();
    test_random_phase(0, 0, 10);
    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d requests, %0d ticks, %0d results over several register settings",
             requests, ticks, answers);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("connectome_spiking_tick_engine test passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_answers.size());
      $display("connectome_spiking_tick_engine test failed");
    end
    $finish;
  end

endmodule
